>>> hw/rtl/clnws_pkg.sv
package clnws_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned NibbleW   = 4;
  localparam int unsigned WaitW     = 8;
  localparam int unsigned StepW     = 5;
  localparam int unsigned ModeW     = 2;

  localparam logic [CmdW-1:0] CMD_TICK  = 2'd0;
  localparam logic [CmdW-1:0] CMD_INIT  = 2'd1;
  localparam logic [CmdW-1:0] CMD_INSTR = 2'd2;
  localparam logic [CmdW-1:0] CMD_DATA  = 2'd3;

  localparam logic [ModeW-1:0] MODE_IDLE  = 2'd0;
  localparam logic [ModeW-1:0] MODE_INIT  = 2'd1;
  localparam logic [ModeW-1:0] MODE_WRITE = 2'd2;

  localparam logic [StepW-1:0] INIT_LAST   = 5'd20;
  localparam logic [StepW-1:0] WRITE_LAST  = 5'd3;
  localparam logic [StepW-1:0] INIT_CHAIN  = 5'd6;
  localparam logic [WaitW-1:0] POWER_UP_WAIT = 8'd31;
  localparam logic [WaitW-1:0] FIRST_GAP     = 8'd5;
  localparam logic [WaitW-1:0] SECOND_GAP    = 8'd1;
  localparam logic [WaitW-1:0] EWT_RESET     = 8'd1;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [ByteW-1:0] byte_value;
  } req_t;

  typedef struct packed {
    logic               pin_rs;
    logic               pin_enable;
    logic [NibbleW-1:0] pin_data;
    logic               busy_res;
    logic               rejected;
    logic               finished;
  } res_t;

  function automatic logic [NibbleW-1:0] init_nibble(input logic [3:0] j);
    logic [NibbleW-1:0] n;
    case (j)
      4'd0, 4'd1, 4'd2: n = 4'h3;
      4'd3, 4'd4:       n = 4'h2;
      4'd5:             n = 4'h8;
      4'd7:             n = 4'hC;
      4'd9:             n = 4'h6;
      default:          n = 4'h0;
    endcase
    return n;
  endfunction

  function automatic logic [WaitW-1:0] init_wait(input logic [StepW-1:0] k,
                                                 input logic [WaitW-1:0] ewt);
    logic [WaitW-1:0] w;
    if (k == '0) begin
      w = POWER_UP_WAIT;
    end else if (k[0]) begin
      w = ewt;
    end else if (k == 5'd2) begin
      w = FIRST_GAP;
    end else if (k == 5'd4) begin
      w = SECOND_GAP;
    end else begin
      w = '0;
    end
    return w;
  endfunction

endpackage

>>> hw/rtl/clnws_ifs.sv
interface clnws_req_if;
  import clnws_pkg::*;
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [ByteW-1:0] byte_value;
  modport source (output valid, output command, output byte_value, input ready);
  modport sink   (input valid, input command, input byte_value, output ready);
endinterface

interface clnws_res_if;
  import clnws_pkg::*;
  logic               valid;
  logic               ready;
  logic               pin_rs;
  logic               pin_enable;
  logic [NibbleW-1:0] pin_data;
  logic               busy_res;
  logic               rejected;
  logic               finished;
  modport source (output valid, output pin_rs, output pin_enable, output pin_data,
                  output busy_res, output rejected, output finished, input ready);
  modport sink   (input valid, input pin_rs, input pin_enable, input pin_data,
                  input busy_res, input rejected, input finished, output ready);
endinterface

interface clnws_cfg_if;
  import clnws_pkg::*;
  logic             valid;
  logic             ready;
  logic [WaitW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/char_lcd_nibble_write_sequencer_unit.sv
// Channel | Dir | Payload                                            | Accepted when
// req_i   | in  | command, byte_value                                | valid && ready
// res_o   | out | pin_rs, pin_enable, pin_data, busy_res, rejected,  | valid && ready
//         |     | finished                                           |
// cfg_i   | in  | data (enable_wait_ticks)                           | valid && ready
//
// Each item passes an input register and a result register, one item per cycle
// sustained while the result is not stalled. The sequencer step and wait counters
// are updated in the cycle the item moves from the input register to the result
// register. Reset returns the sequencer to idle and enable_wait_ticks to 1.
// A stalled result holds the result register and a full input register; cfg_i is always ready.
module char_lcd_nibble_write_sequencer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  clnws_req_if.sink         req_i,
  clnws_res_if.source       res_o,
  clnws_cfg_if.sink         cfg_i
);
  import clnws_pkg::*;

  logic               in_valid_q;
  req_t               in_q;
  logic               out_valid_q;
  res_t               out_q;
  logic               fire;

  logic [WaitW-1:0]   ewt_q;
  logic [ModeW-1:0]   mode_q, mode_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [WaitW-1:0]   wait_q, wait_d;
  logic [ByteW-1:0]   byte_q, byte_d;
  logic               rs_q, rs_d;
  logic               en_q, en_d;
  logic [NibbleW-1:0] bus_q, bus_d;
  res_t               res_d;

  logic               run, found, apply, rejected, finished;
  logic [StepW-1:0]   s, k, kk;
  logic [WaitW-1:0]   w1;

  assign fire        = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || fire;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    mode_d   = mode_q;
    step_d   = step_q;
    wait_d   = wait_q;
    byte_d   = byte_q;
    rs_d     = rs_q;
    en_d     = en_q;
    bus_d    = bus_q;
    rejected = 1'b0;
    finished = 1'b0;
    run      = 1'b0;
    s        = step_q;
    w1       = (wait_q == '0) ? '0 : wait_q - 1'b1;
    found    = 1'b0;
    k        = '0;
    kk       = '0;
    apply    = 1'b0;

    if (in_q.command == CMD_TICK) begin
      if (mode_q != MODE_IDLE) begin
        wait_d = w1;
        run    = (w1 == '0);
      end
    end else if (mode_q != MODE_IDLE) begin
      rejected = 1'b1;
    end else begin
      s      = '0;
      step_d = '0;
      wait_d = '0;
      run    = 1'b1;
      if (in_q.command == CMD_INIT) begin
        mode_d = MODE_INIT;
      end else begin
        mode_d = MODE_WRITE;
        byte_d = in_q.byte_value;
        rs_d   = (in_q.command == CMD_DATA);
      end
    end

    // Find the first action from step s that loads a nonzero wait; all actions
    // before it chain within this item and only its pin levels remain visible.
    if (run) begin
      if (mode_d == MODE_INIT) begin
        if (ewt_q != '0) begin
          if (s <= INIT_LAST && (s < INIT_CHAIN || s[0])) begin
            found = 1'b1;
            k     = s;
          end else if (s < INIT_LAST) begin
            found = 1'b1;
            k     = s + 1'b1;
          end
        end else if (s == '0) begin
          found = 1'b1;
          k     = 5'd0;
        end else if (s <= 5'd2) begin
          found = 1'b1;
          k     = 5'd2;
        end else if (s <= 5'd4) begin
          found = 1'b1;
          k     = 5'd4;
        end
        kk    = found ? k : INIT_LAST;
        apply = found || (s <= INIT_LAST);
        if (apply) begin
          rs_d = 1'b0;
          en_d = kk[0];
          bus_d = (kk == '0) ? '0 : init_nibble(4'((kk - 1'b1) >> 1));
        end
        if (found) begin
          wait_d = init_wait(k, ewt_q);
        end
      end else begin
        if (ewt_q != '0 && s <= WRITE_LAST) begin
          found = 1'b1;
          k     = s;
        end
        kk    = found ? k : WRITE_LAST;
        apply = found || (s <= WRITE_LAST);
        if (apply) begin
          en_d  = !kk[0];
          bus_d = (kk < 5'd2) ? byte_d[ByteW-1 -: NibbleW] : byte_d[NibbleW-1:0];
        end
        if (found) begin
          wait_d = ewt_q;
        end
      end
      if (found) begin
        step_d = k + 1'b1;
      end else begin
        mode_d   = MODE_IDLE;
        step_d   = '0;
        finished = 1'b1;
      end
    end

    res_d.pin_rs     = rs_d;
    res_d.pin_enable = en_d;
    res_d.pin_data   = bus_d;
    res_d.busy_res   = (mode_d != MODE_IDLE);
    res_d.rejected   = rejected;
    res_d.finished   = finished;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ewt_q       <= EWT_RESET;
      mode_q      <= MODE_IDLE;
      step_q      <= '0;
      wait_q      <= '0;
      byte_q      <= '0;
      rs_q        <= 1'b0;
      en_q        <= 1'b0;
      bus_q       <= '0;
    end else begin
      if (cfg_i.valid) begin
        ewt_q <= cfg_i.data;
      end
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        mode_q      <= mode_d;
        step_q      <= step_d;
        wait_q      <= wait_d;
        byte_q      <= byte_d;
        rs_q        <= rs_d;
        en_q        <= en_d;
        bus_q       <= bus_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.command    <= req_i.command;
      in_q.byte_value <= req_i.byte_value;
    end
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.pin_rs     = out_q.pin_rs;
  assign res_o.pin_enable = out_q.pin_enable;
  assign res_o.pin_data   = out_q.pin_data;
  assign res_o.busy_res   = out_q.busy_res;
  assign res_o.rejected   = out_q.rejected;
  assign res_o.finished   = out_q.finished;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import clnws_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned QUIET_LIMIT = 500;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam int unsigned NUM_PHASES = 5;
  localparam int unsigned INIT_STEPS = 21;
  localparam int unsigned WRITE_STEPS = 4;
  localparam logic [WaitW-1:0] SETTLING_TICKS = 8'd31;
  localparam logic [NibbleW-1:0] POWER_UP_NIBBLE [10] = '{
    4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8, 4'h0, 4'hC, 4'h0, 4'h6
  };
  localparam logic [WaitW-1:0] POWER_UP_GAP [10] = '{
    8'd5, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  typedef struct packed {
    bit               is_cfg;
    logic [WaitW-1:0] cfg_value;
    logic [CmdW-1:0]  command;
    logic [ByteW-1:0] byte_value;
    bit               typed;
    res_t             known;
  } script_row_t;

  localparam res_t NO_RES = '0;
  localparam int unsigned SCRIPT_LEN = 23;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{1'b0, 8'h00, CMD_TICK,  8'h00, 1'b1, '{1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 8'h00, CMD_DATA,  8'hFF, 1'b1, '{1'b1, 1'b1, 4'hF, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 8'h00, CMD_INIT,  8'h00, 1'b1, '{1'b1, 1'b1, 4'hF, 1'b1, 1'b1, 1'b0}},
    '{1'b0, 8'h00, CMD_DATA,  8'h00, 1'b1, '{1'b1, 1'b1, 4'hF, 1'b1, 1'b1, 1'b0}},
    '{1'b0, 8'h00, CMD_INSTR, 8'h55, 1'b1, '{1'b1, 1'b1, 4'hF, 1'b1, 1'b1, 1'b0}},
    '{1'b0, 8'h00, CMD_TICK,  8'h00, 1'b0, NO_RES},
    '{1'b0, 8'h00, CMD_TICK,  8'hFF, 1'b0, NO_RES},
    '{1'b0, 8'h00, CMD_TICK,  8'h00, 1'b0, NO_RES},
    '{1'b0, 8'h00, CMD_TICK,  8'h00, 1'b1, '{1'b1, 1'b0, 4'hF, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 8'h00, CMD_INSTR, 8'h00, 1'b1, '{1'b0, 1'b1, 4'h0, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 8'h00, CMD_TICK,  8'h00, 1'b0, NO_RES},
    '{1'b0, 8'h00, CMD_TICK,  8'h00, 1'b0, NO_RES},
    '{1'b0, 8'h00, CMD_TICK,  8'h00, 1'b0, NO_RES},
    '{1'b0, 8'h00, CMD_TICK,  8'h00, 1'b0, NO_RES},
    '{1'b1, 8'h00, CMD_TICK,  8'h00, 1'b0, NO_RES},
    '{1'b0, 8'h00, CMD_DATA,  8'hA5, 1'b1, '{1'b1, 1'b0, 4'h5, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 8'h00, CMD_INSTR, 8'h3C, 1'b1, '{1'b0, 1'b0, 4'hC, 1'b0, 1'b0, 1'b1}},
    '{1'b0, 8'h00, CMD_TICK,  8'h00, 1'b1, '{1'b0, 1'b0, 4'hC, 1'b0, 1'b0, 1'b0}},
    '{1'b0, 8'h00, CMD_INIT,  8'h00, 1'b1, '{1'b0, 1'b0, 4'h0, 1'b1, 1'b0, 1'b0}},
    '{1'b1, 8'h06, CMD_TICK,  8'h00, 1'b0, NO_RES},
    '{1'b0, 8'h00, CMD_DATA,  8'h80, 1'b1, '{1'b1, 1'b1, 4'h8, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 8'h00, CMD_INIT,  8'h00, 1'b1, '{1'b1, 1'b1, 4'h8, 1'b1, 1'b1, 1'b0}},
    '{1'b0, 8'h00, CMD_TICK,  8'h00, 1'b0, NO_RES}
  };

  logic clk_i;
  logic rst_ni = 1'b0;

  clnws_req_if req_if ();
  clnws_res_if res_if ();
  clnws_cfg_if cfg_if ();

  char_lcd_nibble_write_sequencer_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  logic [ModeW-1:0]   lcd_mode;
  logic [5:0]         lcd_step;
  logic [WaitW-1:0]   lcd_wait;
  logic [ByteW-1:0]   lcd_byte;
  logic [WaitW-1:0]   enable_wait;
  logic               lcd_rs;
  logic               lcd_en;
  logic [NibbleW-1:0] lcd_bus;
  bit                 lcd_ignored;

  res_t        pin_queue [$];
  int unsigned mismatches;
  int unsigned gap_odds;
  int unsigned stall_odds;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [WaitW-1:0] lcd_action();
    logic [5:0] k;
    logic [3:0] j;
    k = lcd_step - 6'd1;
    j = 4'(k >> 1);
    if (lcd_mode == MODE_INIT) begin
      if (lcd_step == '0) begin
        lcd_bus = '0;
        lcd_rs = 1'b0;
        lcd_en = 1'b0;
        return SETTLING_TICKS;
      end
      if (!k[0]) begin
        lcd_rs = 1'b0;
        lcd_bus = POWER_UP_NIBBLE[j];
        lcd_en = 1'b1;
        return enable_wait;
      end
      lcd_en = 1'b0;
      return POWER_UP_GAP[j];
    end
    if (!lcd_step[0]) begin
      lcd_bus = (lcd_step == '0) ? lcd_byte[7:4] : lcd_byte[3:0];
      lcd_en = 1'b1;
    end else begin
      lcd_en = 1'b0;
    end
    return enable_wait;
  endfunction

  // Runs every action whose wait has run out; returns 1 when the sequence ends.
  function automatic bit lcd_chain();
    int unsigned steps;
    while (lcd_mode != MODE_IDLE && lcd_wait == '0) begin
      steps = (lcd_mode == MODE_INIT) ? INIT_STEPS : WRITE_STEPS;
      if (lcd_step >= steps) begin
        lcd_mode = MODE_IDLE;
        lcd_step = '0;
        return 1'b1;
      end
      lcd_wait = lcd_action();
      lcd_step = lcd_step + 6'd1;
    end
    return 1'b0;
  endfunction

  function automatic res_t lcd_predict(input logic [CmdW-1:0] cmd,
                                       input logic [ByteW-1:0] val);
    res_t r;
    bit   rej;
    bit   fin;
    rej = 1'b0;
    fin = 1'b0;
    lcd_ignored = 1'b0;
    if (cmd == CMD_TICK) begin
      if (lcd_mode != MODE_IDLE) begin
        if (lcd_wait != '0) lcd_wait = lcd_wait - 8'd1;
        fin = lcd_chain();
      end else begin
        lcd_ignored = 1'b1;
      end
    end else if (lcd_mode != MODE_IDLE) begin
      rej = 1'b1;
      lcd_ignored = 1'b1;
    end else begin
      lcd_step = '0;
      lcd_wait = '0;
      if (cmd == CMD_INIT) begin
        lcd_mode = MODE_INIT;
      end else begin
        lcd_mode = MODE_WRITE;
        lcd_byte = val;
        lcd_rs = (cmd == CMD_DATA);
      end
      fin = lcd_chain();
    end
    r.pin_rs = lcd_rs;
    r.pin_enable = lcd_en;
    r.pin_data = lcd_bus;
    r.busy_res = (lcd_mode != MODE_IDLE);
    r.rejected = rej;
    r.finished = fin;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 10;
    endcase
  endfunction

  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] val,
                           input bit typed, input res_t known);
    res_t predicted;
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.byte_value <= val;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = lcd_predict(cmd, val);
    pin_queue.push_back(typed ? known : predicted);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (pin_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The sequence is run out and the pipeline emptied before the wait is changed.
  task automatic retune(input logic [WaitW-1:0] value);
    while (lcd_mode != MODE_IDLE) send_item(CMD_TICK, 8'($urandom), 1'b0, NO_RES);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    enable_wait = value;
  endtask

  task automatic pick_item(output logic [CmdW-1:0] cmd, output logic [ByteW-1:0] val);
    int unsigned r;
    val = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (lcd_mode != MODE_IDLE) begin
      cmd = (r < 10) ? 2'($urandom_range(1, 3)) : CMD_TICK;
    end else if (r < 15) begin
      cmd = CMD_INIT;
    end else if (r < 50) begin
      cmd = CMD_INSTR;
    end else if (r < 85) begin
      cmd = CMD_DATA;
    end else begin
      cmd = CMD_TICK;
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pin_queue.size() == 0) begin
        $error("result item arrived with nothing expected");
        mismatches++;
      end else begin
        want = pin_queue.pop_front();
        check_field("pin_rs", want.pin_rs, res_if.pin_rs);
        check_field("pin_enable", want.pin_enable, res_if.pin_enable);
        check_field("pin_data", want.pin_data, res_if.pin_data);
        check_field("busy_res", want.busy_res, res_if.busy_res);
        check_field("rejected", want.rejected, res_if.rejected);
        check_field("finished", want.finished, res_if.finished);
      end
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [CmdW-1:0]  cmd;
    logic [ByteW-1:0] val;
    int unsigned      done;
    req_if.valid <= 1'b0;
    req_if.command <= CMD_TICK;
    req_if.byte_value <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    mismatches = 0;
    gap_odds = 4;
    stall_odds = 4;
    lcd_mode = MODE_IDLE;
    lcd_step = '0;
    lcd_wait = '0;
    lcd_byte = '0;
    enable_wait = EWT_RESET;
    lcd_rs = 1'b0;
    lcd_en = 1'b0;
    lcd_bus = '0;
    lcd_ignored = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].is_cfg) begin
        retune(SCRIPT[i].cfg_value);
      end else begin
        send_item(SCRIPT[i].command, SCRIPT[i].byte_value, SCRIPT[i].typed,
                  SCRIPT[i].known);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == NUM_PHASES - 1) begin
        gap_odds = 0;
        stall_odds = 0;
      end else begin
        gap_odds = pick_odds();
        stall_odds = pick_odds();
      end
      retune(8'($urandom_range(0, 5)));
      done = 0;
      while (done < PHASE_ITEMS) begin
        pick_item(cmd, val);
        send_item(cmd, val, 1'b0, NO_RES);
        if (!lcd_ignored) done++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/clnws_pkg.sv
hw/rtl/clnws_ifs.sv
hw/rtl/char_lcd_nibble_write_sequencer_unit.sv
tb/tb.sv
